FILE: design/mvd_pkg.sv
// shared types and constants for the 16-bit mov decoder
// no dependencies; every other file imports this package
`default_nettype none

package mvd_pkg;

   // opcode classification
   localparam logic [3:0] IMM_OPCODE_HIGH = 4'hB;
   localparam logic [5:0] MOV_RM_OPCODE   = 6'h22;
   localparam logic [2:0] DIRECT_RM       = 3'd6;
   localparam logic [1:0] MOD_REGISTER    = 2'd3;
   localparam logic [1:0] MOD_MEMORY      = 2'd0;
   localparam logic [1:0] MOD_DISP8       = 2'd1;
   localparam logic [1:0] MOD_DISP16      = 2'd2;

   // instruction lengths
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   typedef enum logic [1:0] {
      FORM_RM          = 2'd0,
      FORM_IMM         = 2'd1,
      FORM_UNSUPPORTED = 2'd2
   } form_type;

   typedef struct packed {
      logic [7:0] code_byte;
   } req_payload_type;

   typedef struct packed {
      form_type           form;
      logic               to_register;
      logic               wide;
      logic [1:0]         mode;
      logic [2:0]         reg_index;
      logic [2:0]         rm_index;
      logic               direct_address;
      logic signed [15:0] displacement;
      logic [15:0]        immediate;
      logic [2:0]         length;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: design/mvd_if.sv
// valid/ready channel interfaces for code bytes and decoded results
// depends on mvd_pkg for the payload types
`default_nettype none

interface mvd_req_if;
   import mvd_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mvd_rsp_if;
   import mvd_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/mvd_decode.sv
// byte phase tracking and field decode for the mov forms
// depends on mvd_pkg; produces at most one result per accepted byte
`default_nettype none

module mvd_decode (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [7:0]               code_byte,
   output logic                          result_valid,
   output mvd_pkg::rsp_payload_type      result
);
   import mvd_pkg::*;

   typedef enum logic [1:0] {
      PHASE_OPCODE = 2'd0,
      PHASE_FIRST  = 2'd1,
      PHASE_SECOND = 2'd2,
      PHASE_THIRD  = 2'd3
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] opcode_ff, opcode_in;
   logic [7:0] modrm_ff, modrm_in;
   logic [7:0] low_ff, low_in;

   logic            imm_latched;
   logic [7:0]      modrm_sel;
   logic [1:0]      sel_mode;
   logic [2:0]      sel_rm;
   rsp_payload_type rm_fields;
   rsp_payload_type imm_fields;
   rsp_payload_type bad_fields;

   assign imm_latched = (opcode_ff[7:4] == IMM_OPCODE_HIGH);
   // in the modrm phase the fields come straight from the byte
   assign modrm_sel   = (phase_ff == PHASE_FIRST) ? code_byte : modrm_ff;
   assign sel_mode    = modrm_sel[7:6];
   assign sel_rm      = modrm_sel[2:0];

   always_comb begin
      bad_fields      = '0;
      bad_fields.form = FORM_UNSUPPORTED;
      bad_fields.length = LEN_ONE;

      rm_fields                = '0;
      rm_fields.form           = FORM_RM;
      rm_fields.to_register    = opcode_ff[1];
      rm_fields.wide           = opcode_ff[0];
      rm_fields.mode           = sel_mode;
      rm_fields.reg_index      = modrm_sel[5:3];
      rm_fields.rm_index       = sel_rm;
      rm_fields.direct_address = (sel_mode == MOD_MEMORY) && (sel_rm == DIRECT_RM);

      imm_fields             = '0;
      imm_fields.form        = FORM_IMM;
      imm_fields.to_register = 1'b1;
      imm_fields.wide        = opcode_ff[3];
      imm_fields.reg_index   = opcode_ff[2:0];

      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      modrm_in     = modrm_ff;
      low_in       = low_ff;
      result_valid = 1'b0;
      result       = bad_fields;

      if (accept) begin
         unique case (phase_ff)
            PHASE_OPCODE: begin
               opcode_in = code_byte;
               if ((code_byte[7:4] == IMM_OPCODE_HIGH) || (code_byte[7:2] == MOV_RM_OPCODE)) begin
                  phase_in = PHASE_FIRST;
               end else begin
                  result_valid = 1'b1;
                  result       = bad_fields;
               end
            end
            PHASE_FIRST: begin
               if (imm_latched) begin
                  if (!opcode_ff[3]) begin
                     result_valid         = 1'b1;
                     result               = imm_fields;
                     result.immediate     = {8'h00, code_byte};
                     result.length        = LEN_TWO;
                     phase_in             = PHASE_OPCODE;
                  end else begin
                     low_in   = code_byte;
                     phase_in = PHASE_SECOND;
                  end
               end else begin
                  modrm_in = code_byte;
                  if ((sel_mode == MOD_REGISTER) ||
                      ((sel_mode == MOD_MEMORY) && (sel_rm != DIRECT_RM))) begin
                     result_valid  = 1'b1;
                     result        = rm_fields;
                     result.length = LEN_TWO;
                     phase_in      = PHASE_OPCODE;
                  end else begin
                     phase_in = PHASE_SECOND;
                  end
               end
            end
            PHASE_SECOND: begin
               if (imm_latched) begin
                  result_valid     = 1'b1;
                  result           = imm_fields;
                  result.immediate = {code_byte, low_ff};
                  result.length    = LEN_THREE;
                  phase_in         = PHASE_OPCODE;
               end else if (modrm_ff[7:6] == MOD_DISP8) begin
                  // short displacement is zero-extended
                  result_valid        = 1'b1;
                  result              = rm_fields;
                  result.displacement = $signed({8'h00, code_byte});
                  result.length       = LEN_THREE;
                  phase_in            = PHASE_OPCODE;
               end else begin
                  low_in   = code_byte;
                  phase_in = PHASE_THIRD;
               end
            end
            PHASE_THIRD: begin
               result_valid        = 1'b1;
               result              = rm_fields;
               result.displacement = $signed({code_byte, low_ff});
               result.length       = LEN_FOUR;
               phase_in            = PHASE_OPCODE;
            end
            default: begin
               phase_in = PHASE_OPCODE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_OPCODE;
         opcode_ff <= '0;
         modrm_ff  <= '0;
         low_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         modrm_ff  <= modrm_in;
         low_ff    <= low_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/mvd_out_buf.sv
// result register with a skid entry behind it
// depends on mvd_pkg for the result payload type
`default_nettype none

module mvd_out_buf (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire mvd_pkg::rsp_payload_type push_data,
   output logic                          can_push,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output mvd_pkg::rsp_payload_type      out_data
);
   import mvd_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type main_ff, main_in;
   rsp_payload_type skid_ff, skid_in;
   logic            main_free;

   assign main_free = !main_valid_ff || out_ready;
   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            // no push can arrive while the skid entry is full
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

FILE: design/x86_mov_decoder.sv
// top level of the byte-serial 16-bit mov decoder
// depends on mvd_pkg, mvd_if, mvd_decode and mvd_out_buf
//
//   channel | dir | payload                         | when
//   req     | in  | code_byte                       | every byte of the stream
//   rsp     | out | decoded fields and length       | last byte of an instruction
//
// a code byte is taken every cycle that req.ready is high; results are registered
// instructions are 1 to 4 bytes, so at most one result per accepted byte
// a stalled result sits in the output register, a second one in the skid entry;
// req.ready drops only while the skid entry is full
// reset returns the decoder to awaiting an opcode and empties the output stage
`default_nettype none

module x86_mov_decoder (
   input wire logic clock,
   input wire logic reset,
   mvd_req_if.sink  req,
   mvd_rsp_if.source rsp
);
   import mvd_pkg::*;

   logic            accept;
   logic            dec_valid;
   logic            can_push;
   rsp_payload_type dec_result;

   assign req.ready = can_push;
   assign accept    = req.valid && can_push;

   mvd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .code_byte    (req.payload.code_byte),
      .result_valid (dec_valid),
      .result       (dec_result)
   );

   mvd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (dec_valid),
      .push_data (dec_result),
      .can_push  (can_push),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.payload)
   );

   // a result is only produced by an accepted byte
   a_result_needs_accept: assert property (@(posedge clock) disable iff (reset)
      dec_valid |-> (req.valid && req.ready))
      else $error("decode result without an accepted item");

   // output stage is empty after reset, so bytes are taken at once
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req.ready)
      else $error("not ready after reset");

   a_unsupported_length: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.payload.form == FORM_UNSUPPORTED)) |->
      (rsp.payload.length == LEN_ONE))
      else $error("unsupported opcode with wrong length");

   a_imm_length: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.payload.form == FORM_IMM)) |->
      (rsp.payload.length == (rsp.payload.wide ? LEN_THREE : LEN_TWO)))
      else $error("immediate form length does not match width");

endmodule

`default_nettype wire

FILE: test/mvd_tb_pkg.sv
// scoreboard for the mov decoder testbench: tracks the byte stream and the decoded results
// depends on mvd_pkg for the result payload type and the opcode constants
`default_nettype none

package mvd_tb_pkg;
   import mvd_pkg::*;

   class mov_decode_scoreboard;
      logic [2:0]      byte_count;
      logic [7:0]      opcode_seen;
      logic [7:0]      modrm_seen;
      logic [7:0]      low_seen;
      rsp_payload_type decoded_q[$];
      int unsigned     error_count;

      function new();
         byte_count  = '0;
         opcode_seen = '0;
         modrm_seen  = '0;
         low_seen    = '0;
         error_count = 0;
      endfunction

      function int unsigned pending();
         return decoded_q.size();
      endfunction

      function rsp_payload_type rm_result(logic [15:0] disp, logic [2:0] len);
         rsp_payload_type r;
         r                = '0;
         r.form           = FORM_RM;
         r.to_register    = opcode_seen[1];
         r.wide           = opcode_seen[0];
         r.mode           = modrm_seen[7:6];
         r.reg_index      = modrm_seen[5:3];
         r.rm_index       = modrm_seen[2:0];
         r.direct_address = (modrm_seen[7:6] == MOD_MEMORY) && (modrm_seen[2:0] == DIRECT_RM);
         r.displacement   = disp;
         r.length         = len;
         return r;
      endfunction

      function rsp_payload_type imm_result(logic [15:0] imm, logic [2:0] len);
         rsp_payload_type r;
         r             = '0;
         r.form        = FORM_IMM;
         r.to_register = 1'b1;
         r.wide        = opcode_seen[3];
         r.reg_index   = opcode_seen[2:0];
         r.immediate   = imm;
         r.length      = len;
         return r;
      endfunction

      // one accepted code byte; pushes the decoded instruction when this byte ends it
      function void note_byte(logic [7:0] b);
         rsp_payload_type r;
         logic            is_imm;
         is_imm = (opcode_seen[7:4] == IMM_OPCODE_HIGH);
         case (byte_count)
            3'd1: begin
               if (is_imm) begin
                  if (!opcode_seen[3]) begin
                     decoded_q.push_back(imm_result({8'h00, b}, LEN_TWO));
                     byte_count = 3'd0;
                  end else begin
                     low_seen   = b;
                     byte_count = 3'd2;
                  end
               end else begin
                  modrm_seen = b;
                  if (b[7:6] == MOD_REGISTER || (b[7:6] == MOD_MEMORY && b[2:0] != DIRECT_RM)) begin
                     decoded_q.push_back(rm_result(16'h0000, LEN_TWO));
                     byte_count = 3'd0;
                  end else begin
                     byte_count = 3'd2;
                  end
               end
            end
            3'd2: begin
               if (is_imm) begin
                  decoded_q.push_back(imm_result({b, low_seen}, LEN_THREE));
                  byte_count = 3'd0;
               end else if (modrm_seen[7:6] == MOD_DISP8) begin
                  // short displacement is zero-extended
                  decoded_q.push_back(rm_result({8'h00, b}, LEN_THREE));
                  byte_count = 3'd0;
               end else begin
                  low_seen   = b;
                  byte_count = 3'd3;
               end
            end
            3'd3: begin
               decoded_q.push_back(rm_result({b, low_seen}, LEN_FOUR));
               byte_count = 3'd0;
            end
            default: begin
               opcode_seen = b;
               if (b[7:4] == IMM_OPCODE_HIGH || b[7:2] == MOV_RM_OPCODE) begin
                  byte_count = 3'd1;
               end else begin
                  // anything else is a one-byte unsupported item, resync on the next byte
                  r          = '0;
                  r.form     = FORM_UNSUPPORTED;
                  r.length   = LEN_ONE;
                  decoded_q.push_back(r);
                  byte_count = 3'd0;
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (decoded_q.size() == 0) begin
            $error("result with nothing outstanding: form %0h length %0h", got.form, got.length);
            error_count++;
         end else begin
            want = decoded_q.pop_front();
            compare_field("form", want.form, got.form);
            compare_field("to_register", want.to_register, got.to_register);
            compare_field("wide", want.wide, got.wide);
            compare_field("mode", want.mode, got.mode);
            compare_field("reg_index", want.reg_index, got.reg_index);
            compare_field("rm_index", want.rm_index, got.rm_index);
            compare_field("direct_address", want.direct_address, got.direct_address);
            compare_field("displacement", want.displacement, got.displacement);
            compare_field("immediate", want.immediate, got.immediate);
            compare_field("length", want.length, got.length);
         end
      endfunction
   endclass

endpackage

`default_nettype wire

FILE: test/tb_top.sv
// top of the mov decoder testbench: clock, reset, byte stream driver and result sink
// depends on mvd_pkg, mvd_if, x86_mov_decoder and the scoreboard in mvd_tb_pkg
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mvd_pkg::*;
   import mvd_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned BYTES_PER_STEP = 250;

   logic clock;
   logic reset;

   mvd_req_if req_chan ();
   mvd_rsp_if rsp_chan ();

   x86_mov_decoder DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   mov_decode_scoreboard decode_board = new();

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned bytes_sent         = 0;
   int unsigned cycle_count        = 0;

   int unsigned idle_steps [4] = '{0, 79, 0, 31};
   int unsigned stall_steps[4] = '{0, 0, 79, 31};

   // opcode and operand extremes, every addressing mode, unsupported opcodes
   logic [7:0] directed_bytes[$] = '{
      8'hB0, 8'h00,
      8'hB7, 8'hFF,
      8'hB8, 8'h00, 8'h00,
      8'hBF, 8'hFF, 8'hFF,
      8'h88, 8'hC0,
      8'h89, 8'h00,
      8'h8A, 8'h06, 8'h00, 8'h80,
      8'h8B, 8'h06, 8'hFF, 8'h7F,
      8'h88, 8'h45, 8'hFF,
      8'h89, 8'h80, 8'h00, 8'h80,
      8'h8B, 8'hBF, 8'hFF, 8'hFF,
      8'h00, 8'hFF, 8'h8C, 8'hA0, 8'hC7
   };

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // accepted items on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            decode_board.note_byte(req_chan.payload.code_byte);
         if (rsp_chan.valid && rsp_chan.ready)
            decode_board.check_result(rsp_chan.payload);
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset)
            rsp_chan.ready = 1'b0;
         else
            rsp_chan.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // valid is held high from presentation until the item is taken
   task automatic send_byte(input logic [7:0] b);
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if ($urandom_range(99) < sender_idle_pct) begin
            req_chan.valid = 1'b0;
         end else begin
            req_chan.valid             = 1'b1;
            req_chan.payload.code_byte = b;
            do @(posedge clock); while (!req_chan.ready);
            taken = 1'b1;
         end
      end
      bytes_sent++;
   endtask

   task automatic send_random_instruction();
      int unsigned pick;
      logic [7:0]  opcode;
      logic [7:0]  modrm;
      pick = $urandom_range(99);
      if (pick < 40) begin
         opcode = {IMM_OPCODE_HIGH, 4'($urandom)};
         send_byte(opcode);
         send_byte(8'($urandom));
         if (opcode[3])
            send_byte(8'($urandom));
      end else if (pick < 85) begin
         opcode = {MOV_RM_OPCODE, 2'($urandom)};
         if ($urandom_range(99) < 15)
            modrm = {MOD_MEMORY, 3'($urandom), DIRECT_RM};
         else
            modrm = 8'($urandom);
         send_byte(opcode);
         send_byte(modrm);
         if (modrm[7:6] == MOD_DISP8) begin
            send_byte(8'($urandom));
         end else if (modrm[7:6] == MOD_DISP16 ||
                      (modrm[7:6] == MOD_MEMORY && modrm[2:0] == DIRECT_RM)) begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
         end
      end else begin
         // noise, which may also cut into or start an instruction
         send_byte(8'($urandom));
      end
   endtask

   // sender holds off until every outstanding result has come out
   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (decode_board.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      reset                      = 1'b1;
      req_chan.valid             = 1'b0;
      req_chan.payload.code_byte = 8'h00;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int step = 0; step < 4; step++) begin
         sender_idle_pct    = idle_steps[step];
         receiver_stall_pct = stall_steps[step];
         if (step == 0) begin
            foreach (directed_bytes[i])
               send_byte(directed_bytes[i]);
         end
         while (bytes_sent < BYTES_PER_STEP * (step + 1))
            send_random_instruction();
         wait_for_results();
      end

      repeat (8) @(posedge clock);
      if (decode_board.error_count == 0 && decode_board.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
